@@ rtl/hashed_trie_key_dictionary_macros.svh @@
// assertion macros for the hashed trie key dictionary
// uses the clk and rst_n names of the including module
`ifndef HASHED_TRIE_KEY_DICTIONARY_MACROS_SVH
`define HASHED_TRIE_KEY_DICTIONARY_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define HTKD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define HTKD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/htkd_pkg.sv @@
// shared constants, codes and controller/datapath types for the trie dictionary
// no dependencies
package htkd_pkg;

    localparam int TABLE_SLOTS = 1024;
    localparam int MAX_NODES   = 256;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int POS_W       = $clog2(TABLE_SLOTS + 32);
    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int LETTER_W    = 5;
    localparam int VALUE_W     = 32;

    localparam logic [7:0] CHAR_A      = 8'h41;
    localparam logic [7:0] CHAR_Z      = 8'h5A;
    localparam logic [7:0] LETTER_BASE = 8'd64;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_FIND   = 1'b1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BROKEN   = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    typedef enum logic [2:0] {
        CS_CLEAR,
        CS_IDLE,
        CS_SLOT_RD,
        CS_SLOT_CHK,
        CS_LINK_CHK,
        CS_FINISH,
        CS_FIND_OUT
    } ctl_state_t;

    typedef struct packed {
        logic load;
        logic clr_wr;
        logic slot_rd;
        logic create;
        logic link_rd;
        logic move;
        logic step;
        logic abort;
        logic fin_insert;
        logic fin_find;
        logic val_out;
        logic err_out;
    } htkd_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic walk_ok;
        logic pos_oob;
        logic owner_zero;
        logic full;
        logic link_match;
        logic is_find;
        logic last;
        logic aborted;
    } htkd_stat_t;

endpackage

@@ rtl/htkd_ctrl.sv @@
// controller state machine for the trie dictionary
// depends on htkd_pkg for the state enum and the command/status structs
module htkd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  htkd_pkg::htkd_stat_t stat,
    output htkd_pkg::htkd_cmd_t  cmd,
    output logic               busy
);
    import htkd_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CS_CLEAR:
            begin
                if (stat.clr_last)
                    state_next = CS_IDLE;
            end
            CS_IDLE:
            begin
                if (start)
                    state_next = CS_SLOT_RD;
            end
            CS_SLOT_RD:
            begin
                if (stat.walk_ok && !stat.pos_oob)
                    state_next = CS_SLOT_CHK;
                else
                    state_next = CS_FINISH;
            end
            CS_SLOT_CHK:
            begin
                if (stat.owner_zero)
                    state_next = CS_FINISH;
                else
                    state_next = CS_LINK_CHK;
            end
            CS_LINK_CHK:
            begin
                if (stat.link_match)
                    state_next = CS_FINISH;
                else
                    state_next = CS_SLOT_RD;
            end
            CS_FINISH:
            begin
                if (stat.last && !stat.aborted && stat.is_find)
                    state_next = CS_FIND_OUT;
                else
                    state_next = CS_IDLE;
            end
            CS_FIND_OUT:
            begin
                state_next = CS_IDLE;
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            CS_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
            end
            CS_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            CS_SLOT_RD:
            begin
                if (stat.walk_ok)
                begin
                    // probe ran off the table end
                    if (stat.pos_oob)
                        cmd.abort = 1'b1;
                    else
                        cmd.slot_rd = 1'b1;
                end
            end
            CS_SLOT_CHK:
            begin
                if (stat.owner_zero)
                begin
                    if (stat.is_find || stat.full)
                        cmd.abort = 1'b1;
                    else
                        cmd.create = 1'b1;
                end
                else
                begin
                    cmd.link_rd = 1'b1;
                end
            end
            CS_LINK_CHK:
            begin
                if (stat.link_match)
                    cmd.move = 1'b1;
                else
                    cmd.step = 1'b1;
            end
            CS_FINISH:
            begin
                if (stat.last)
                begin
                    if (stat.aborted)
                        cmd.err_out = 1'b1;
                    else if (stat.is_find)
                        cmd.fin_find = 1'b1;
                    else
                        cmd.fin_insert = 1'b1;
                end
            end
            CS_FIND_OUT:
            begin
                cmd.val_out = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ rtl/htkd_dp.sv @@
// datapath for the trie dictionary: slot table, node records, walk registers, result beat
// depends on htkd_pkg for sizes, codes and the command/status structs
module htkd_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  htkd_pkg::htkd_cmd_t          cmd,
    output htkd_pkg::htkd_stat_t         stat,
    input  logic                         op,
    input  logic [7:0]                   ch,
    input  logic                         last,
    input  logic signed [htkd_pkg::VALUE_W-1:0] value,
    output logic                         done,
    output logic signed [htkd_pkg::VALUE_W-1:0] result_value,
    output logic [1:0]                   status,
    output logic                         is_key
);
    import htkd_pkg::*;

    // memories
    logic [NODE_W-1:0]            slot_mem [TABLE_SLOTS];
    logic [LETTER_W+NODE_W-1:0]   link_mem [MAX_NODES];
    logic [VALUE_W:0]             val_mem  [MAX_NODES];

    // latched item
    logic                  op_reg;
    logic [LETTER_W-1:0]   letter_reg;
    logic                  letter_ok_reg;
    logic                  last_reg;
    logic [VALUE_W-1:0]    value_reg;

    // walk state
    logic [POS_W-1:0]      pos_reg;
    logic [NODE_W-1:0]     cur_reg;
    logic [LETTER_W-1:0]   cur_letter_reg;
    logic [NODE_W-1:0]     nodes_used_reg;
    logic                  aborted_reg;
    logic [SLOT_W-1:0]     clr_cnt_reg;
    logic                  find_root_reg;
    logic [VALUE_W-1:0]    root_val_reg;
    logic                  root_key_reg;
    logic                  done_reg;

    // registered read data
    logic [NODE_W-1:0]            owner_q;
    logic [LETTER_W+NODE_W-1:0]   link_q;
    logic [VALUE_W:0]             val_q;

    logic [VALUE_W-1:0]    result_value_reg;
    logic [1:0]            status_reg;
    logic                  is_key_reg;

    logic [7:0]            letter_full;
    logic [NODE_W-1:0]     new_node;
    logic                  cur_is_root;

    logic                  slot_we;
    logic [SLOT_W-1:0]     slot_waddr;
    logic [NODE_W-1:0]     slot_wdata;
    logic                  val_we;
    logic [NODE_W-1:0]     val_waddr;
    logic [VALUE_W:0]      val_wdata;

    assign letter_full = ch - LETTER_BASE;
    assign new_node    = nodes_used_reg + NODE_W'(1);
    assign cur_is_root = (cur_reg == '0);

    always_comb
    begin
        stat.clr_last   = (clr_cnt_reg == SLOT_W'(TABLE_SLOTS - 1));
        stat.walk_ok    = letter_ok_reg && !aborted_reg;
        stat.pos_oob    = (pos_reg >= POS_W'(TABLE_SLOTS));
        stat.owner_zero = (owner_q == '0);
        stat.full       = (nodes_used_reg == NODE_W'(MAX_NODES - 1));
        stat.link_match = (link_q == {letter_reg, cur_reg});
        stat.is_find    = (op_reg == OP_FIND);
        stat.last       = last_reg;
        stat.aborted    = aborted_reg;
    end

    // slot table write port: clearing pass or new child
    always_comb
    begin
        slot_we    = cmd.clr_wr || cmd.create;
        slot_waddr = cmd.clr_wr ? clr_cnt_reg : pos_reg[SLOT_W-1:0];
        slot_wdata = cmd.clr_wr ? '0 : new_node;
    end

    // value store write port: fresh node or final insert beat
    always_comb
    begin
        val_we    = cmd.create || (cmd.fin_insert && !cur_is_root);
        val_waddr = cmd.create ? new_node : cur_reg;
        val_wdata = cmd.create ? '0 : {1'b1, value_reg};
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
            slot_mem[slot_waddr] <= slot_wdata;
        if (cmd.slot_rd)
            owner_q <= slot_mem[pos_reg[SLOT_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.create)
            link_mem[new_node] <= {letter_reg, cur_reg};
        if (cmd.link_rd)
            link_q <= link_mem[owner_q];
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
            val_mem[val_waddr] <= val_wdata;
        if (cmd.fin_find)
            val_q <= val_mem[cur_reg];
    end

    // item latch and probe position
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg        <= op;
            letter_reg    <= letter_full[LETTER_W-1:0];
            letter_ok_reg <= (ch >= CHAR_A) && (ch <= CHAR_Z);
            last_reg      <= last;
            value_reg     <= value;
            pos_reg       <= POS_W'(cur_letter_reg) + POS_W'(letter_full[LETTER_W-1:0]);
        end
        else if (cmd.step)
        begin
            pos_reg <= pos_reg + POS_W'(letter_reg);
        end
        if (cmd.fin_find)
            find_root_reg <= cur_is_root;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg        <= '0;
            cur_letter_reg <= '0;
            nodes_used_reg <= '0;
            aborted_reg    <= 1'b0;
            clr_cnt_reg    <= '0;
            root_val_reg   <= '0;
            root_key_reg   <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.err_out || cmd.fin_insert || cmd.val_out;
            if (cmd.clr_wr)
                clr_cnt_reg <= clr_cnt_reg + SLOT_W'(1);
            if (cmd.abort)
                aborted_reg <= 1'b1;
            if (cmd.create)
            begin
                nodes_used_reg <= new_node;
                cur_reg        <= new_node;
                cur_letter_reg <= letter_reg;
            end
            else if (cmd.move)
            begin
                cur_reg        <= owner_q;
                cur_letter_reg <= letter_reg;
            end
            else if (cmd.err_out || cmd.fin_insert || cmd.fin_find)
            begin
                // key ends: back to the root
                cur_reg        <= '0;
                cur_letter_reg <= '0;
                aborted_reg    <= 1'b0;
            end
            if (cmd.fin_insert && cur_is_root)
            begin
                root_val_reg <= value_reg;
                root_key_reg <= 1'b1;
            end
        end
    end

    // result beat
    always_ff @(posedge clk)
    begin
        if (cmd.err_out)
        begin
            result_value_reg <= '0;
            status_reg       <= (op_reg == OP_FIND) ? STATUS_BROKEN : STATUS_OVERFLOW;
            is_key_reg       <= 1'b0;
        end
        else if (cmd.fin_insert)
        begin
            result_value_reg <= '0;
            status_reg       <= STATUS_OK;
            is_key_reg       <= 1'b1;
        end
        else if (cmd.val_out)
        begin
            result_value_reg <= find_root_reg ? root_val_reg : val_q[VALUE_W-1:0];
            status_reg       <= STATUS_OK;
            is_key_reg       <= find_root_reg ? root_key_reg : val_q[VALUE_W];
        end
    end

    assign done         = done_reg;
    assign result_value = result_value_reg;
    assign status       = status_reg;
    assign is_key       = is_key_reg;

endmodule

@@ rtl/hashed_trie_key_dictionary.sv @@
// top level of the hashed trie key dictionary: controller plus datapath
// depends on htkd_pkg, htkd_ctrl, htkd_dp and hashed_trie_key_dictionary_macros.svh
//
// channel   handshake        payload                        beat taken when
// command   start / busy     op, ch, last, value            start && !busy
// result    done             result_value, status, is_key   done (one cycle)
//
// while busy after reset the slot table clears one entry a cycle, TABLE_SLOTS (1024) in all
// after an accepted beat busy spans SLOT_RD then FINISH for a skipped character or one of
// an aborted key; each probe miss passes SLOT_RD, SLOT_CHK and LINK_CHK, a matched letter
// passes them again then FINISH, a created node or an empty slot SLOT_RD, SLOT_CHK, FINISH,
// a probe off the table end SLOT_RD and FINISH; a probe reads the slot table, then the node
// record if owned; a clean final find adds FIND_OUT; done is registered and cannot be held off
`include "hashed_trie_key_dictionary_macros.svh"

module hashed_trie_key_dictionary (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                op,
    input  logic [7:0]                          ch,
    input  logic                                last,
    input  logic signed [htkd_pkg::VALUE_W-1:0] value,
    output logic                                done,
    output logic signed [htkd_pkg::VALUE_W-1:0] result_value,
    output logic [1:0]                          status,
    output logic                                is_key
);
    import htkd_pkg::*;

    htkd_cmd_t  cmd;
    htkd_stat_t dp_stat;

    htkd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (dp_stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    htkd_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (dp_stat),
        .op           (op),
        .ch           (ch),
        .last         (last),
        .value        (value),
        .done         (done),
        .result_value (result_value),
        .status       (status),
        .is_key       (is_key)
    );

    `HTKD_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
    `HTKD_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe held for two cycles")
    `HTKD_ASSERT_SAME(a_err_clean, done && (status != STATUS_OK), (result_value == '0) && !is_key, "error result carries value or key mark")

endmodule

@@ verif/tb.sv @@
// self-checking testbench for the hashed trie key dictionary
// depends on htkd_pkg and the hashed_trie_key_dictionary top level
// keeps its own copy of the trie and checks every result beat against it
module tb;
    import htkd_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int END_WAIT    = 800;

    typedef struct packed {
        logic signed [VALUE_W-1:0] val;
        logic [1:0]                stat;
        logic                      key_flag;
    } lookup_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic                      op;
    logic [7:0]                ch;
    logic                      last;
    logic signed [VALUE_W-1:0] value;
    logic                      done;
    logic signed [VALUE_W-1:0] result_value;
    logic [1:0]                status;
    logic                      is_key;

    // shadow trie
    int                     slot_node [TABLE_SLOTS];
    int                     node_char [MAX_NODES];
    int                     node_up   [MAX_NODES];
    bit                     node_end  [MAX_NODES];
    bit signed [VALUE_W-1:0] node_val [MAX_NODES];
    int                     walk_node;
    int                     node_count;
    bit                     key_dead;

    lookup_result_t lookup_q[$];
    int             error_count;
    int             stall_cycles;
    int             chars_sent;
    int             burst_left;

    hashed_trie_key_dictionary DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .ch           (ch),
        .last         (last),
        .value        (value),
        .done         (done),
        .result_value (result_value),
        .status       (status),
        .is_key       (is_key)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // move the walk one letter down; zero means the path broke or the trie is full
    function automatic bit trie_descend(input int letter, input bit creating);
        int cur;
        int pos;
        int owner;
        cur = walk_node;
        pos = node_char[cur] + letter;
        while (pos < TABLE_SLOTS)
        begin
            owner = slot_node[pos];
            if (owner == 0)
            begin
                if (!creating || node_count + 1 >= MAX_NODES)
                    return 1'b0;
                node_count++;
                slot_node[pos]        = node_count;
                node_char[node_count] = letter;
                node_up[node_count]   = cur;
                node_end[node_count]  = 1'b0;
                node_val[node_count]  = '0;
                walk_node             = node_count;
                return 1'b1;
            end
            if (node_up[owner] == cur && node_char[owner] == letter)
            begin
                walk_node = owner;
                return 1'b1;
            end
            pos += letter;
        end
        return 1'b0;
    endfunction

    function automatic void trie_step(input logic key_op, input logic [7:0] key_ch,
                                      input logic key_last,
                                      input logic signed [VALUE_W-1:0] key_val);
        lookup_result_t res;
        if (!key_dead && key_ch >= CHAR_A && key_ch <= CHAR_Z)
        begin
            if (!trie_descend(int'(key_ch) - int'(LETTER_BASE), key_op == OP_INSERT))
                key_dead = 1'b1;
        end
        if (!key_last)
            return;
        if (key_dead)
        begin
            res.val      = '0;
            res.stat     = (key_op == OP_FIND) ? STATUS_BROKEN : STATUS_OVERFLOW;
            res.key_flag = 1'b0;
        end
        else if (key_op == OP_FIND)
        begin
            res.val      = node_val[walk_node];
            res.stat     = STATUS_OK;
            res.key_flag = node_end[walk_node];
        end
        else
        begin
            node_end[walk_node] = 1'b1;
            node_val[walk_node] = key_val;
            res.val             = '0;
            res.stat            = STATUS_OK;
            res.key_flag        = 1'b1;
        end
        walk_node = 0;
        key_dead  = 1'b0;
        lookup_q.push_back(res);
    endfunction

    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c >= CHAR_A && c <= CHAR_Z);
        return c;
    endfunction

    // one command beat, then a random gap at the end of a burst
    task automatic send_char(input logic key_op, input logic [7:0] key_ch, input logic key_last,
                             input logic signed [VALUE_W-1:0] key_val);
        int gap;
        @(negedge clk);
        start <= 1'b1;
        op    <= key_op;
        ch    <= key_ch;
        last  <= key_last;
        value <= key_val;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        trie_step(key_op, key_ch, key_last, key_val);
        chars_sent++;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(0, 24);
            gap        = $urandom_range(1, 10);
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        else
            burst_left--;
    endtask

    task automatic send_word(input logic key_op, input string word,
                             input logic signed [VALUE_W-1:0] key_val);
        for (int i = 0; i < word.len(); i++)
            send_char(key_op, word[i], i == word.len() - 1, key_val);
    endtask

    task automatic send_random_key(input logic key_op, input int letters,
                                   input int min_len, input int max_len);
        int   len;
        bit   junk_tail;
        logic this_op;
        len       = $urandom_range(min_len, max_len);
        junk_tail = (len == 0) || ($urandom_range(0, 9) == 0);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_char(1'($urandom_range(0, 1)), junk_char(), 1'b0, $urandom);
            // now and then a character of the other kind inside the key
            this_op = ($urandom_range(0, 19) == 0) ? ~key_op : key_op;
            send_char(this_op, CHAR_A + 8'($urandom_range(0, letters - 1)),
                      (i == len - 1) && !junk_tail, $urandom);
        end
        if (junk_tail)
            send_char(key_op, junk_char(), 1'b1, $urandom);
    endtask

    task automatic wait_results();
        @(negedge clk);
        start <= 1'b0;
        burst_left = 0;
        while (lookup_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        send_word(OP_INSERT, "AB", 32'sh7FFFFFFF);
        send_word(OP_FIND, "AB", 32'sh0);
        send_word(OP_FIND, "A", 32'sh0);
        // skipped characters around a key, last mark on a skipped one
        send_char(OP_INSERT, 8'h00, 1'b0, 32'sh0);
        send_char(OP_INSERT, "A", 1'b0, 32'sh0);
        send_char(OP_INSERT, 8'hFF, 1'b1, 32'sh80000000);
        send_char(OP_FIND, 8'h61, 1'b0, 32'sh0);
        send_char(OP_FIND, "A", 1'b1, 32'sh0);
        // empty key lands on the root
        send_char(OP_INSERT, 8'h20, 1'b1, 32'sd12345);
        send_char(OP_FIND, 8'h7F, 1'b1, 32'sh0);
        // broken path ignores the rest of the key
        send_word(OP_FIND, "QZA", 32'sh0);
        // mixed kinds, the final character decides
        send_char(OP_INSERT, "C", 1'b0, 32'sh0);
        send_char(OP_FIND, "D", 1'b1, 32'sh0);
        send_char(OP_FIND, "A", 1'b0, 32'sh0);
        send_char(OP_INSERT, "B", 1'b1, 32'sh5A5A5A5A);
        send_char(OP_FIND, "X", 1'b0, 32'sh0);
        send_char(OP_INSERT, "Y", 1'b1, 32'sh1);
        // letter range edges
        send_char(OP_INSERT, 8'h40, 1'b0, 32'sh0);
        send_char(OP_INSERT, "Z", 1'b0, 32'sh0);
        send_char(OP_INSERT, 8'h5B, 1'b1, 32'shFFFFFFFF);
        send_char(OP_FIND, "Z", 1'b1, 32'sh0);
    endtask

    // a chain of Z children walks its probe off the table end
    task automatic test_deep_chain();
        string zs;
        zs = "";
        for (int i = 0; i < 45; i++)
            zs = {zs, "Z"};
        send_word(OP_INSERT, zs, $urandom);
        send_word(OP_FIND, zs, $urandom);
        send_word(OP_FIND, zs.substr(0, 19), $urandom);
    endtask

    task automatic test_random_keys();
        int pick;
        int next_pause;
        next_pause = chars_sent + 120;
        while (chars_sent < 560)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                send_random_key(OP_INSERT, 5, 0, 3);
            else if (pick < 85)
                send_random_key(OP_FIND, 5, 0, 3);
            else
                repeat ($urandom_range(1, 4))
                    send_char(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                              $urandom_range(0, 3) == 0, $urandom);
            if (chars_sent >= next_pause)
            begin
                wait_results();
                next_pause = chars_sent + 120;
            end
        end
    endtask

    // fill the node store, then keep inserting and finding past the limit
    task automatic test_capacity();
        int keys;
        keys = 0;
        while (node_count < MAX_NODES - 1 && keys < 80)
        begin
            send_random_key(OP_INSERT, 26, 3, 8);
            keys++;
        end
        repeat (10)
        begin
            send_random_key(OP_INSERT, 26, 2, 5);
            send_random_key(OP_FIND, 5, 1, 3);
        end
    endtask

    always @(posedge clk)
    begin
        lookup_result_t want;
        if ((start && !busy && rst_n) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (done === 1'b1)
        begin
            if (lookup_q.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result beat at %0t: value %0d status %0d key %0b",
                             $time, result_value, status, is_key);
            end
            else
            begin
                want = lookup_q.pop_front();
                if (result_value !== want.val || status !== want.stat
                    || is_key !== want.key_flag)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch at %0t: want %0d/%0d/%0b got %0d/%0d/%0b",
                                 $time, want.val, want.stat, want.key_flag,
                                 result_value, status, is_key);
                end
            end
        end
    end

    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        op           = OP_INSERT;
        ch           = 8'h00;
        last         = 1'b0;
        value        = '0;
        walk_node    = 0;
        node_count   = 0;
        key_dead     = 1'b0;
        chars_sent   = 0;
        burst_left   = 0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_deep_chain();
        test_random_keys();
        test_capacity();

        wait_results();
        repeat (END_WAIT) @(posedge clk);
        if (error_count == 0 && lookup_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
